FILE: rtl/mtg_pkg.sv
// Shared types and constants of the MT19937 generator.
package mtg_pkg;

    localparam int WORD_W       = 32;
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int IDX_W        = 10;

    localparam logic [WORD_W-1:0] MATRIX_WORD  = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

    // Configuration port: one register, selected by address bit 2.
    localparam int           PADDR_W  = 3;
    localparam logic [0:0]   REG_SEED = 1'b0;

    // A queued request as the engine sees it.
    typedef struct packed {
        logic              do_init;
        logic [WORD_W-1:0] seed;
    } t_cmd;

    typedef struct packed {
        logic idle;
    } t_eng_status;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_INIT,
        ENG_TW_PRIME,
        ENG_TW_LOAD,
        ENG_TW_RD,
        ENG_TW_WR,
        ENG_RD_ISSUE,
        ENG_RD_DATA
    } t_eng_state;

endpackage

FILE: rtl/mtg_front.sv
// Front end: seed register, configuration port and request classification.
module mtg_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mtg_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_push,
    input  logic                       i_restart,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output mtg_pkg::t_cmd              o_cmd
);

    logic [mtg_pkg::WORD_W-1:0] r_seed;
    logic                       r_inited;
    logic                       w_sel_seed;

    assign w_sel_seed = (paddr[mtg_pkg::PADDR_W-1:2] == mtg_pkg::REG_SEED);
    assign pready     = 1'b1;
    assign prdata     = w_sel_seed ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mtg_pkg::DEFAULT_SEED;
        end else if (psel && penable && pwrite && w_sel_seed) begin
            r_seed <= pwdata;
        end
    end

    // Every request leaves the state initialised, so the flag sets on the first one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inited <= 1'b0;
        end else if (o_q_push) begin
            r_inited <= 1'b1;
        end
    end

    assign o_q_push      = i_push && !i_q_full;
    assign o_cmd.do_init = i_restart || !r_inited;
    assign o_cmd.seed    = i_restart ? r_seed : mtg_pkg::DEFAULT_SEED;

endmodule

FILE: rtl/mtg_cmd_fifo.sv
// Short request queue between the front end and the engine.
module mtg_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtg_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mtg_pkg::t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    mtg_pkg::t_cmd    r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slots[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mtg_engine.sv
// Back end: state memory, initialisation, twist, read-out and tempering.
module mtg_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  mtg_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [mtg_pkg::WORD_W-1:0] o_random_word,
    output mtg_pkg::t_eng_status       o_status
);

    localparam int W = mtg_pkg::WORD_W;
    localparam int N = mtg_pkg::IDX_W;
    localparam logic [N-1:0] LAST_IDX  = N'(mtg_pkg::STATE_WORDS - 1);
    localparam logic [N-1:0] WORDS_IDX = N'(mtg_pkg::STATE_WORDS);
    localparam logic [N-1:0] UNINIT    = N'(mtg_pkg::STATE_WORDS + 1);
    localparam logic [N-1:0] FAR_FWD   = N'(mtg_pkg::TWIST_OFFSET);
    localparam logic [N-1:0] FAR_BACK  = N'(mtg_pkg::STATE_WORDS - mtg_pkg::TWIST_OFFSET);

    function automatic logic [W-1:0] mix_pair(input logic [W-1:0] upper,
                                              input logic [W-1:0] lower);
        logic [W-1:0] y;
        y = (upper & mtg_pkg::HIGH_BIT) | (lower & mtg_pkg::LOW_BITS);
        return (y >> 1) ^ (y[0] ? mtg_pkg::MATRIX_WORD : '0);
    endfunction

    function automatic logic [W-1:0] temper(input logic [W-1:0] v);
        logic [W-1:0] y;
        y = v;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    mtg_pkg::t_eng_state r_state;
    mtg_pkg::t_eng_state n_state;

    logic [W-1:0] r_mem [mtg_pkg::STATE_WORDS];
    logic [W-1:0] r_rd_a;
    logic [W-1:0] r_rd_b;
    logic [W-1:0] r_prev;
    logic [W-1:0] r_upper;
    logic [W-1:0] r_out;
    logic         r_ov;
    logic [N-1:0] r_cnt;
    logic [N-1:0] r_idx;

    logic         w_wr_en;
    logic [N-1:0] w_wr_addr;
    logic [W-1:0] w_wr_data;
    logic         w_rd_a_en;
    logic [N-1:0] w_rd_a_addr;
    logic         w_rd_b_en;
    logic [N-1:0] w_rd_b_addr;
    logic         w_out_load;
    logic         w_slot_free;
    logic [W-1:0] w_init_mix;
    logic [W-1:0] w_init_word;
    logic [W-1:0] w_twist_word;
    logic [N-1:0] w_next_k;
    logic [N-1:0] w_far_k;

    assign w_init_mix   = r_prev ^ (r_prev >> 30);
    assign w_init_word  = (mtg_pkg::INIT_MULT * w_init_mix) + {{(W-N){1'b0}}, r_cnt};
    assign w_twist_word = r_rd_b ^ mix_pair(r_upper, r_rd_a);
    assign w_next_k     = (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
    assign w_far_k      = (r_cnt < FAR_BACK) ? r_cnt + FAR_FWD : r_cnt - FAR_BACK;
    assign w_slot_free  = !r_ov || i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mtg_pkg::ENG_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.do_init) begin
                        n_state = mtg_pkg::ENG_INIT;
                    end else if (r_idx >= WORDS_IDX) begin
                        n_state = mtg_pkg::ENG_TW_PRIME;
                    end else begin
                        n_state = mtg_pkg::ENG_RD_ISSUE;
                    end
                end
            end
            mtg_pkg::ENG_INIT: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = mtg_pkg::ENG_TW_PRIME;
                end
            end
            mtg_pkg::ENG_TW_PRIME: n_state = mtg_pkg::ENG_TW_LOAD;
            mtg_pkg::ENG_TW_LOAD:  n_state = mtg_pkg::ENG_TW_RD;
            mtg_pkg::ENG_TW_RD:    n_state = mtg_pkg::ENG_TW_WR;
            mtg_pkg::ENG_TW_WR: begin
                n_state = (r_cnt == LAST_IDX) ? mtg_pkg::ENG_RD_ISSUE : mtg_pkg::ENG_TW_RD;
            end
            mtg_pkg::ENG_RD_ISSUE: n_state = mtg_pkg::ENG_RD_DATA;
            mtg_pkg::ENG_RD_DATA: begin
                if (w_slot_free) begin
                    n_state = mtg_pkg::ENG_IDLE;
                end
            end
            default: n_state = mtg_pkg::ENG_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_cnt;
        w_wr_data   = w_init_word;
        w_rd_a_en   = 1'b0;
        w_rd_a_addr = r_idx;
        w_rd_b_en   = 1'b0;
        w_rd_b_addr = w_far_k;
        w_out_load  = 1'b0;
        case (r_state)
            mtg_pkg::ENG_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid && i_cmd.do_init) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = '0;
                    w_wr_data = i_cmd.seed;
                end
            end
            mtg_pkg::ENG_INIT: begin
                w_wr_en = 1'b1;
            end
            mtg_pkg::ENG_TW_PRIME: begin
                w_rd_a_en   = 1'b1;
                w_rd_a_addr = '0;
            end
            mtg_pkg::ENG_TW_RD: begin
                w_rd_a_en   = 1'b1;
                w_rd_a_addr = w_next_k;
                w_rd_b_en   = 1'b1;
            end
            mtg_pkg::ENG_TW_WR: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_twist_word;
            end
            mtg_pkg::ENG_RD_ISSUE: begin
                w_rd_a_en = 1'b1;
            end
            mtg_pkg::ENG_RD_DATA: begin
                w_out_load = w_slot_free;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_a_en) begin
            r_rd_a <= r_mem[w_rd_a_addr];
        end
        if (w_rd_b_en) begin
            r_rd_b <= r_mem[w_rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mtg_pkg::ENG_IDLE: begin
                r_prev <= i_cmd.seed;
            end
            mtg_pkg::ENG_INIT: begin
                r_prev <= w_init_word;
            end
            mtg_pkg::ENG_TW_LOAD, mtg_pkg::ENG_TW_WR: begin
                r_upper <= r_rd_a;
            end
            default: begin
                r_prev <= r_prev;
            end
        endcase
        if (w_out_load) begin
            r_out <= temper(r_rd_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtg_pkg::ENG_IDLE;
            r_idx   <= UNINIT;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                mtg_pkg::ENG_IDLE: begin
                    r_cnt <= N'(1);
                end
                mtg_pkg::ENG_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_idx <= WORDS_IDX;
                end
                mtg_pkg::ENG_TW_PRIME: begin
                    r_cnt <= '0;
                end
                mtg_pkg::ENG_TW_WR: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_idx <= '0;
                end
                mtg_pkg::ENG_RD_ISSUE: begin
                    r_idx <= r_idx + 1'b1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_ov;
    assign o_random_word = r_out;
    assign o_status.idle = (r_state == mtg_pkg::ENG_IDLE);

endmodule

FILE: rtl/mersenne_twister_generator.sv
// Top level of the MT19937 pseudo-random word generator.

// Each request on the input queue asks for one tempered 32-bit word, and with
// restart set it first re-seeds the 624-word state from the seed register
// (address 0 of the configuration port, 5489 after reset). A request made
// before any initialisation seeds the state from the fixed value 5489, and a
// seed write only takes effect at the next restart. Requests enter a short
// queue in front of a sequential engine that owns the state memory, so new
// requests are taken while the engine works and while a word waits to be
// popped. An ordinary draw takes the request, reads the state word from
// memory and tempers it into the output register once the previous word
// has been popped. Every 624th draw is preceded by a twist of the whole
// state, which walks the memory word by word (two read ports, one write
// port). A restart adds the initialisation recurrence, one multiply and
// add for each word after the seed, which is written while the request is
// taken. The state memory needs no clearing pass after reset, since it is
// always filled before use.
module mersenne_twister_generator #(
    parameter int CMD_DEPTH = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtg_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_restart,
    output logic                        empty,
    input  logic                        pop,
    output logic [31:0]                 o_random_word
);

    mtg_pkg::t_cmd        w_cmd_in;
    mtg_pkg::t_cmd        w_cmd_out;
    mtg_pkg::t_eng_status w_eng_st;
    logic                 w_q_push;
    logic                 w_q_pop;
    logic                 w_q_valid;
    logic                 w_q_full;

    // Front end: holds the seed and decides whether a request must initialise.
    mtg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_push    (push),
        .i_restart (i_restart),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_cmd     (w_cmd_in)
    );

    // The queue decouples request acceptance from the long initialise and
    // twist passes of the engine.
    mtg_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_cmd_out)
    );

    mtg_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_q_valid),
        .i_cmd         (w_cmd_out),
        .o_cmd_pop     (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_random_word (o_random_word),
        .o_status      (w_eng_st)
    );

    assign full = w_q_full;

    // The engine only takes a request that the queue really holds.
    a_pop_has_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("engine took a request from an empty queue");

    // With nothing queued and the engine idle, no word can appear next cycle.
    a_no_spurious_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_eng_st.idle && !w_q_valid && empty) |=> empty)
        else $error("result produced without a request");

    // A full queue must also report a waiting request to the engine.
    a_full_has_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> w_q_valid)
        else $error("queue full and empty at once");

endmodule
